FILE: src/ghb_markov_prefetcher_unit_defines.svh
// Assertion macros used by the checker file gmpu_checker.sv.
`ifndef GHB_MARKOV_PREFETCHER_UNIT_DEFINES_SVH
`define GHB_MARKOV_PREFETCHER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define GMPU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ghb prefetcher check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define GMPU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ghb prefetcher check failed");

`endif

FILE: src/gmpu_pkg.sv
`default_nettype none
package gmpu_pkg;

  localparam int HISTORY_DEPTH = 1024;
  localparam int INDEX_ENTRIES = 1024;
  localparam int WAYS          = 4;
  localparam int WALK_LIMIT    = 16;
  localparam int ADDRESS_BITS  = 48;

  localparam int ADDR_W  = 48;
  localparam int PC_W    = 8;
  localparam int SETS    = INDEX_ENTRIES / WAYS;
  localparam int HIST_AW = $clog2(HISTORY_DEPTH);
  localparam int SET_AW  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int RLEN_W  = $clog2(WAYS + 1);
  localparam int STEP_W  = $clog2(WALK_LIMIT + 1);
  localparam int CAND_W  = (WALK_LIMIT > 1) ? $clog2(WALK_LIMIT) : 1;

  localparam logic [ADDR_W-1:0] ADDR_MASK =
    (ADDRESS_BITS >= ADDR_W) ? {ADDR_W{1'b1}}
                             : ADDR_W'((65'd1 << ADDRESS_BITS) - 65'd1);

  typedef struct packed {
    logic [WAYS-1:0]              used;
    logic [WAYS-1:0][ADDR_W-1:0]  tag;
    logic [WAYS-1:0][HIST_AW-1:0] ptr;
    logic [RLEN_W-1:0]            rlen;
    logic [WAYS-1:0][WAY_W-1:0]   rord;  // most recent first
  } set_row_t;

  typedef struct packed {
    logic accept;
    logic clear;
    logic lookup;
    logic walk;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic hit;
    logic matched;
    logic walk_end;
  } status_t;

endpackage
`default_nettype wire

FILE: src/gmpu_datapath.sv
`default_nettype none
module gmpu_datapath
  import gmpu_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cmd_t              cmd,
  output status_t                status,
  input  wire logic [ADDR_W-1:0] in_addr,
  input  wire logic [PC_W-1:0]   in_pc,
  input  wire logic              in_hit,
  output logic                   out_valid_bit,
  output logic [ADDR_W-1:0]      out_addr,
  output logic                   out_matched
);

  // history ring
  logic [ADDR_W-1:0]  hist_addr_mem [HISTORY_DEPTH];
  logic [HIST_AW-1:0] hist_link_mem [HISTORY_DEPTH];
  logic [ADDR_W-1:0]  addr_rd;
  logic [HIST_AW-1:0] link_rd;
  logic [HIST_AW-1:0] head;
  logic               wrapped;

  // index sets with recency
  set_row_t           set_mem [SETS];
  set_row_t           row_rd;
  set_row_t           row_wr;
  logic [SET_AW-1:0]  clr_idx;

  logic [ADDR_W-1:0]  addr_q;
  logic [SET_AW-1:0]  set_q;
  logic               hit_q;
  logic               matched_q;

  // walk and tally
  logic [HIST_AW-1:0] cur, cur_next, nxt;
  logic [STEP_W-1:0]  step;
  logic [ADDR_W-1:0]  cand [WALK_LIMIT];
  logic [STEP_W-1:0]  cnt  [WALK_LIMIT];
  logic [STEP_W-1:0]  ncand;
  logic [CAND_W-1:0]  best;
  logic [STEP_W-1:0]  best_cnt;

  logic [WAYS-1:0]    way_hit;
  logic               any_hit;
  logic [WAY_W-1:0]   mway, vway, tway;
  logic               cur_wr, nxt_wr, walk_end;
  logic [ADDR_W-1:0]  follower;
  logic               found;
  logic [CAND_W-1:0]  fidx;
  logic [STEP_W-1:0]  fcnt;

  function automatic logic is_written(input logic [HIST_AW-1:0] i,
                                      input logic [HIST_AW-1:0] h,
                                      input logic w);
    return w || (i < h);
  endfunction

  function automatic set_row_t touch(input set_row_t r, input logic [WAY_W-1:0] w);
    set_row_t          o;
    logic [RLEN_W-1:0] pos;
    logic              fnd;
    o   = r;
    pos = r.rlen;
    fnd = 1'b0;
    for (int i = 0; i < WAYS; i++) begin
      if (!fnd && (RLEN_W'(i) < r.rlen) && (r.rord[i] == w)) begin
        pos = RLEN_W'(i);
        fnd = 1'b1;
      end
    end
    if (!fnd) begin
      if (r.rlen < RLEN_W'(WAYS)) begin
        o.rlen = r.rlen + RLEN_W'(1);
        pos    = r.rlen;
      end else begin
        pos = RLEN_W'(WAYS - 1);
      end
    end
    for (int i = 1; i < WAYS; i++) begin
      if (RLEN_W'(i) <= pos) o.rord[i] = r.rord[i-1];
    end
    o.rord[0] = w;
    return o;
  endfunction

  // lookup against the registered set row
  always_comb begin
    way_hit = '0;
    for (int w = 0; w < WAYS; w++) begin
      way_hit[w] = row_rd.used[w] && (row_rd.tag[w] == addr_q);
    end
    any_hit = |way_hit;
    mway = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (way_hit[w]) mway = WAY_W'(w);
    end
    // victim: first empty way, else least recent
    if (&row_rd.used) begin
      vway = (row_rd.rlen != '0) ? row_rd.rord[row_rd.rlen - RLEN_W'(1)] : '0;
    end else begin
      vway = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
        if (!row_rd.used[w]) vway = WAY_W'(w);
      end
    end
    tway = any_hit ? mway : vway;
    row_wr = touch(row_rd, tway);
    row_wr.used[tway] = 1'b1;
    row_wr.tag[tway]  = addr_q;
    row_wr.ptr[tway]  = head;
  end

  // walk step
  always_comb begin
    nxt      = cur + HIST_AW'(1);
    cur_wr   = is_written(cur, head, wrapped);
    nxt_wr   = is_written(nxt, head, wrapped);
    follower = nxt_wr ? addr_rd : '0;
    walk_end = !cur_wr || (link_rd == cur) || (step == STEP_W'(WALK_LIMIT - 1));
    found = 1'b0;
    fidx  = '0;
    for (int k = 0; k < WALK_LIMIT; k++) begin
      if ((STEP_W'(k) < ncand) && (cand[k] == follower)) begin
        found = 1'b1;
        fidx  = CAND_W'(k);
      end
    end
    fcnt = cnt[fidx] + STEP_W'(1);
    if (cmd.lookup) begin
      cur_next = any_hit ? row_rd.ptr[mway] : cur;
    end else if (cmd.walk && !walk_end) begin
      cur_next = link_rd;
    end else begin
      cur_next = cur;
    end
  end

  always_ff @(posedge clk) begin
    addr_rd <= hist_addr_mem[cur_next + HIST_AW'(1)];
    link_rd <= hist_link_mem[cur_next];
    if (cmd.lookup) begin
      hist_addr_mem[head] <= addr_q;
      hist_link_mem[head] <= any_hit ? row_rd.ptr[mway] : head;
    end
  end

  always_ff @(posedge clk) begin
    row_rd <= set_mem[set_q];
    if (cmd.clear) begin
      set_mem[clr_idx] <= '0;
    end else if (cmd.lookup) begin
      set_mem[set_q] <= row_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      wrapped <= 1'b0;
      clr_idx <= '0;
    end else begin
      if (cmd.clear) clr_idx <= clr_idx + SET_AW'(1);
      if (cmd.lookup) begin
        head <= head + HIST_AW'(1);
        if (head == HIST_AW'(HISTORY_DEPTH - 1)) wrapped <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
    if (cmd.accept) begin
      addr_q    <= in_addr & ADDR_MASK;
      set_q     <= SET_AW'(in_pc);
      hit_q     <= in_hit;
      matched_q <= 1'b0;
      ncand     <= '0;
      best      <= '0;
      best_cnt  <= '0;
    end
    if (cmd.lookup) begin
      matched_q <= any_hit;
      step      <= '0;
    end
    if (cmd.walk) begin
      step <= step + STEP_W'(1);
      if (cur_wr) begin
        if (found) begin
          cnt[fidx] <= fcnt;
          if ((fcnt > best_cnt) || ((fcnt == best_cnt) && (fidx < best))) begin
            best     <= fidx;
            best_cnt <= fcnt;
          end
        end else begin
          cand[ncand[CAND_W-1:0]] <= follower;
          cnt[ncand[CAND_W-1:0]]  <= STEP_W'(1);
          ncand                   <= ncand + STEP_W'(1);
          if (ncand == '0) begin
            best     <= '0;
            best_cnt <= STEP_W'(1);
          end
        end
      end
    end
    if (cmd.load_out) begin
      out_valid_bit <= !hit_q && matched_q && (ncand != '0);
      out_addr      <= (!hit_q && matched_q && (ncand != '0)) ? cand[best] : '0;
      out_matched   <= !hit_q && matched_q;
    end
  end

  always_comb begin
    status.clear_last = (clr_idx == SET_AW'(SETS - 1));
    status.hit        = hit_q;
    status.matched    = any_hit;
    status.walk_end   = walk_end;
  end

endmodule
`default_nettype wire

FILE: src/gmpu_controller.sv
`default_nettype none
module gmpu_controller
  import gmpu_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire status_t status,
  output cmd_t         cmd,
  input  wire logic    in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  wire logic    out_ready
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_LOOKUP, S_PRIME, S_WALK, S_DONE
  } state_t;

  state_t state;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd          = '0;
    cmd.accept   = in_ready && in_valid;
    cmd.clear    = (state == S_CLEAR);
    cmd.lookup   = (state == S_LOOKUP) && !status.hit;
    cmd.walk     = (state == S_WALK);
    cmd.load_out = (state == S_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      // a new beat may replace one that leaves in the same cycle
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR:  if (status.clear_last) state <= S_IDLE;
        S_IDLE:   if (in_valid) state <= S_READ;
        S_READ:   state <= status.hit ? S_DONE : S_LOOKUP;
        S_LOOKUP: state <= status.matched ? S_PRIME : S_DONE;
        S_PRIME:  state <= S_WALK;
        S_WALK:   if (status.walk_end) state <= S_DONE;
        S_DONE:   if (out_free) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: src/ghb_markov_prefetcher_unit.sv
`default_nettype none
// Markov prefetcher over a global history buffer. Each input beat is one
// cache access; each gives exactly one output beat. A hit passes through
// the read and done states. A miss also passes a lookup state and, on an
// index match, a prime state and a walk of at most WALK_LIMIT chain
// entries; the walk is set by the one-read-per-cycle history memory.
// One access is processed at a time. After reset the index memory is
// swept clear, one set per cycle, before the first beat.
module ghb_markov_prefetcher_unit
  import gmpu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [55:0] s_tdata,  // [47:0] miss_address, [55:48] pc_set_bits
  input  wire logic [0:0]  s_tuser,  // [0] was_hit
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,  // [47:0] prefetch_address
  output logic [1:0]       m_tuser   // [0] prefetch_valid, [1] index_matched
);

  cmd_t    cmd;
  status_t status;

  gmpu_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .status    (status),
    .cmd       (cmd),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready)
  );

  gmpu_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .in_addr       (s_tdata[ADDR_W-1:0]),
    .in_pc         (s_tdata[ADDR_W+PC_W-1:ADDR_W]),
    .in_hit        (s_tuser[0]),
    .out_valid_bit (m_tuser[0]),
    .out_addr      (m_tdata),
    .out_matched   (m_tuser[1])
  );

endmodule
`default_nettype wire

FILE: src/gmpu_checker.sv
`default_nettype none
`include "ghb_markov_prefetcher_unit_defines.svh"
module gmpu_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [47:0] m_tdata,
  input wire logic [1:0]  m_tuser
);

  // a prefetch only comes from a matched chain
  `GMPU_ASSERT_NOW(a_pf_needs_match, m_tvalid && m_tuser[0], m_tuser[1])
  // no prefetch means a zero address
  `GMPU_ASSERT_NOW(a_pf_addr_zero, m_tvalid && !m_tuser[0], m_tdata == 48'd0)
  // one access in flight at a time
  `GMPU_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)
  `GMPU_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
                    m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind ghb_markov_prefetcher_unit gmpu_checker u_chk (.*);
`default_nettype wire

FILE: test/ghb_markov_prefetcher_checker.sv
`timescale 1ns / 100ps
module ghb_markov_prefetcher_checker
  import gmpu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [55:0] s_tdata,   // [47:0] miss_address, [55:48] pc_set_bits
  input  wire logic [0:0]  s_tuser,   // [0] was_hit
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [47:0] m_tdata,   // [47:0] prefetch_address
  input  wire logic [1:0]  m_tuser,   // [0] prefetch_valid, [1] index_matched
  output int               fail_count,
  output int               pending
);

  typedef struct packed {
    logic        pf_valid;
    logic [47:0] pf_addr;
    logic        matched;
  } prefetch_t;

  logic [47:0]        hist_addr [HISTORY_DEPTH];
  logic [HIST_AW-1:0] hist_link [HISTORY_DEPTH];
  logic               hist_wr   [HISTORY_DEPTH];
  logic [47:0]        idx_tag   [INDEX_ENTRIES];
  logic [HIST_AW-1:0] idx_ptr   [INDEX_ENTRIES];
  logic               idx_used  [INDEX_ENTRIES];
  int                 lru_list  [SETS][WAYS];
  int                 lru_len   [SETS];
  int                 head;
  prefetch_t          expected_prefetches[$];

  initial begin
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      hist_addr[i] = '0; hist_link[i] = '0; hist_wr[i] = 0;
    end
    for (int i = 0; i < INDEX_ENTRIES; i++) begin
      idx_tag[i] = '0; idx_ptr[i] = '0; idx_used[i] = 0;
    end
    for (int s = 0; s < SETS; s++) lru_len[s] = 0;
    head = 0;
  end

  assign pending = expected_prefetches.size();

  function automatic void touch(int set, int way);
    int n;
    int pos;
    n = lru_len[set];
    pos = n;
    for (int i = 0; i < n; i++)
      if (lru_list[set][i] == way && pos == n) pos = i;
    if (pos == n) begin
      if (n < WAYS) begin
        n++;
        lru_len[set] = n;
      end
      pos = n - 1;
    end
    for (int i = pos; i > 0; i--) lru_list[set][i] = lru_list[set][i-1];
    lru_list[set][0] = way;
  endfunction

  function automatic void push_history(logic [47:0] a, logic [HIST_AW-1:0] link);
    hist_addr[head] = a;
    hist_link[head] = link;
    hist_wr[head] = 1;
    head = (head + 1) % HISTORY_DEPTH;
  endfunction

  function automatic prefetch_t predict_prefetch(logic [47:0] a, logic [7:0] pc,
                                                 logic hit);
    prefetch_t r;
    int set;
    int way;
    int e;
    int cur;
    int ncand;
    int k;
    int best;
    logic [47:0] cand [WALK_LIMIT];
    int cnt [WALK_LIMIT];
    logic [47:0] nxt;
    r = '0;
    a = a & ADDR_MASK;
    set = pc % SETS;
    if (hit) return r;
    for (way = 0; way < WAYS; way++) begin
      e = set + way * SETS;
      if (idx_used[e] && idx_tag[e] == a) begin
        ncand = 0;
        cur = idx_ptr[e];
        push_history(a, HIST_AW'(cur));
        for (int step = 0; step < WALK_LIMIT; step++) begin
          if (!hist_wr[cur]) break;
          nxt = hist_addr[(cur + 1) % HISTORY_DEPTH];
          for (k = 0; k < ncand; k++)
            if (cand[k] == nxt) break;
          if (k == ncand) begin
            cand[ncand] = nxt;
            cnt[ncand] = 1;
            ncand++;
          end else begin
            cnt[k]++;
          end
          if (hist_link[cur] == cur) break;
          cur = hist_link[cur];
        end
        if (ncand > 0) begin
          best = 0;
          for (k = 1; k < ncand; k++)
            if (cnt[k] > cnt[best]) best = k;
          r.pf_valid = 1;
          r.pf_addr = cand[best];
        end
        r.matched = 1;
        idx_ptr[e] = HIST_AW'((head + HISTORY_DEPTH - 1) % HISTORY_DEPTH);
        touch(set, way);
        return r;
      end
    end
    for (way = 0; way < WAYS; way++)
      if (!idx_used[set + way * SETS]) break;
    if (way == WAYS) begin
      way = (lru_len[set] > 0) ? lru_list[set][lru_len[set] - 1] : 0;
      if (way >= WAYS) way = 0;
    end
    e = set + way * SETS;
    idx_tag[e] = a;
    idx_ptr[e] = HIST_AW'(head);
    idx_used[e] = 1;
    touch(set, way);
    push_history(a, HIST_AW'(head));
    return r;
  endfunction

  always @(posedge clk) begin
    prefetch_t got;
    prefetch_t exp_r;
    if (!rst) begin
      if (s_tvalid && s_tready)
        expected_prefetches.push_back(
          predict_prefetch(s_tdata[47:0], s_tdata[55:48], s_tuser[0]));
      if (m_tvalid && m_tready) begin
        got = '{pf_valid: m_tuser[0], pf_addr: m_tdata, matched: m_tuser[1]};
        if (expected_prefetches.size() == 0) begin
          $display("%0t: unexpected beat, actual %h", $time, got);
          fail_count++;
        end else begin
          exp_r = expected_prefetches.pop_front();
          if (got.pf_valid !== exp_r.pf_valid) begin
            $display("%0t: prefetch_valid expected %0d actual %0d", $time,
                     exp_r.pf_valid, got.pf_valid);
            fail_count++;
          end
          if (got.pf_addr !== exp_r.pf_addr) begin
            $display("%0t: prefetch_address expected %h actual %h", $time,
                     exp_r.pf_addr, got.pf_addr);
            fail_count++;
          end
          if (got.matched !== exp_r.matched) begin
            $display("%0t: index_matched expected %0d actual %0d", $time,
                     exp_r.matched, got.matched);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

FILE: test/tb_ghb_markov_prefetcher_unit.sv
`timescale 1ns / 100ps
module tb_ghb_markov_prefetcher_unit;
  import gmpu_pkg::*;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;  // [47:0] miss_address, [55:48] pc_set_bits
  logic [0:0]  s_tuser = '0;  // [0] was_hit
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [47:0] m_tdata;       // [47:0] prefetch_address
  logic [1:0]  m_tuser;       // [0] prefetch_valid, [1] index_matched
  int          fail_count;
  int          pending;
  int          cycles = 0;

  // small pools so that tags recur and chains grow
  logic [47:0] addr_pool [8];
  logic [7:0]  pc_pool [4];

  always #6 clk = ~clk;

  ghb_markov_prefetcher_unit dut (.*);

  ghb_markov_prefetcher_checker chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // output stall: per beat, a random wait then ready until the beat moves
  initial begin
    int w;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      w = $urandom_range(0, 13);
      if ($urandom_range(0, 3) == 0) w = 0;
      if (w > 0) begin
        m_tready <= 0;
        repeat (w) @(posedge clk);
      end
      m_tready <= 1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  task automatic send_access(logic [47:0] a, logic [7:0] pc, logic hit, bit burst);
    int w;
    w = burst ? 0 : $urandom_range(0, 13);
    if (w > 0) begin
      s_tvalid <= 0;
      repeat (w) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {pc, a};
    s_tuser <= hit;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic random_access(bit burst);
    int r;
    logic [47:0] a;
    logic [7:0] pc;
    r = $urandom_range(0, 99);
    if (r < 80) begin
      a = addr_pool[$urandom_range(0, 7)];
      pc = pc_pool[$urandom_range(0, 3)];
    end else begin
      a = 48'({$urandom, $urandom});
      pc = 8'($urandom);
    end
    send_access(a, pc, ($urandom_range(0, 9) == 0), burst);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 0;
    // directed: extremes, hit, repeats, set conflicts, wraps of way eviction
    send_access(48'hFFFF_FFFF_FFFF, 8'hFF, 1'b0, 1'b0);
    send_access(48'h0, 8'h00, 1'b0, 1'b0);
    send_access(48'h0, 8'h00, 1'b0, 1'b0);
    send_access(48'hFFFF_FFFF_FFFF, 8'hFF, 1'b1, 1'b0);
    send_access(48'hFFFF_FFFF_FFFF, 8'hFF, 1'b0, 1'b0);
    for (int i = 0; i < 3; i++) begin
      send_access(48'h1000, 8'h01, 1'b0, 1'b1);
      send_access(48'h2000, 8'h01, 1'b0, 1'b1);
      send_access(48'h3000, 8'h01, 1'b0, 1'b0);
    end
    for (int i = 0; i < 6; i++) send_access(48'h5000 + i, 8'h02, 1'b0, 1'b0);
    send_access(48'h5001, 8'h02, 1'b0, 1'b0);
    send_access(48'hAAAA_5555_AAAA, 8'hAA, 1'b0, 1'b0);
    send_access(48'h5555_AAAA_5555, 8'h55, 1'b0, 1'b0);
    for (int i = 0; i < 20; i++) send_access(48'h7777, 8'h03, 1'b0, 1'b1);
    s_tvalid <= 0;
    // hold off until the block drains
    while (pending != 0) @(posedge clk);
    for (int p = 0; p < 16; p++) begin
      for (int i = 0; i < 8; i++) addr_pool[i] = 48'({$urandom, $urandom});
      for (int i = 0; i < 4; i++) pc_pool[i] = 8'($urandom);
      for (int i = 0; i < 40; i++) random_access(p % 4 == 1);
    end
    s_tvalid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
